// ===== design/kaf_pkg.sv =====
`default_nettype none

package kaf_pkg;

	localparam int DW = 48;
	localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

	// Scratch memory layout, one 48-bit word per entry.
	localparam int MEM_DEPTH = 64;
	localparam int NSTATE    = 12;
	localparam int M_X    = 0;
	localparam int M_P    = 3;
	localparam int M_HALF = 12;
	localparam int M_XM   = 13;
	localparam int M_AP   = 16;
	localparam int M_PM   = 25;
	localparam int M_S00  = 34;
	localparam int M_S11  = 35;
	localparam int M_T1   = 36;
	localparam int M_T2   = 37;
	localparam int M_DET  = 38;
	localparam int M_I00  = 39;
	localparam int M_I01  = 40;
	localparam int M_I10  = 41;
	localparam int M_I11  = 42;
	localparam int M_NS01 = 43;
	localparam int M_NS10 = 44;
	localparam int M_Y0   = 45;
	localparam int M_Y1   = 46;
	localparam int M_K    = 47;
	localparam int M_IKH  = 53;

	// Operand codes with the top bit set select a value that is not in memory.
	localparam logic [6:0] SP_ZERO = 7'h40;
	localparam logic [6:0] SP_ONE  = 7'h41;
	localparam logic [6:0] SP_DT   = 7'h42;
	localparam logic [6:0] SP_Q    = 7'h43;
	localparam logic [6:0] SP_RALT = 7'h44;
	localparam logic [6:0] SP_RACC = 7'h45;
	localparam logic [6:0] SP_ALT  = 7'h46;
	localparam logic [6:0] SP_ACC  = 7'h47;

	localparam logic [2:0] REG_TIME_STEP     = 3'd0;
	localparam logic [2:0] REG_PROCESS_NOISE = 3'd1;
	localparam logic [2:0] REG_ALT_NOISE     = 3'd2;
	localparam logic [2:0] REG_ACCEL_NOISE   = 3'd3;
	localparam logic [2:0] REG_INIT_ALT      = 3'd4;

	typedef enum logic [3:0] {
		OP_MAC, OP_MULH, OP_DIV, OP_ADD, OP_SUB, OP_NEG, OP_BZ, OP_JMP, OP_OUT, OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_FETCH, ST_EXEC, ST_MUL, ST_DIV, ST_WB, ST_DONE
	} state_t;

	typedef struct packed {
		op_t        op;
		logic       clr;
		logic       wr;
		logic [6:0] a;
		logic [6:0] b;
		logic [5:0] dst;
		logic [7:0] tgt;
	} instr_t;

	localparam int PROG_LEN = 256;
	typedef instr_t [PROG_LEN-1:0] prog_t;

	function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
		return s[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} - {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
		return s[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] sneg(input logic signed [DW-1:0] a);
		return (a == VMIN) ? VMAX : -a;
	endfunction

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
		return a[DW-1] ? DW'(-a) : DW'(a);
	endfunction

	function automatic logic [6:0] mo(input int idx);
		return 7'(idx);
	endfunction

	// Transition matrix entry A[i][k].
	function automatic logic [6:0] a_op(input int i, input int k);
		if (i == k) return SP_ONE;
		if (k == i + 1) return SP_DT;
		if (i == 0 && k == 2) return mo(M_HALF);
		return SP_ZERO;
	endfunction

	// Entry of I - K*H; the middle column never depends on the gain.
	function automatic logic [6:0] ik_op(input int i, input int k);
		if (k == 1) return (i == 1) ? SP_ONE : SP_ZERO;
		return mo(M_IKH + 3 * i + k);
	endfunction

	function automatic instr_t mk(input op_t op, input logic clr, input logic wr,
			input logic [6:0] a, input logic [6:0] b, input int dst);
		instr_t r;
		r.op  = op;
		r.clr = clr;
		r.wr  = wr;
		r.a   = a;
		r.b   = b;
		r.dst = 6'(dst);
		r.tgt = 8'd0;
		return r;
	endfunction

	function automatic prog_t build_prog();
		prog_t p;
		int n;
		int bz_pos;
		int jp_pos;
		for (int x = 0; x < PROG_LEN; x++) p[x] = mk(OP_DONE, 1'b0, 1'b0, SP_ZERO, SP_ZERO, 0);
		n = 0;
		// Predict.
		p[n] = mk(OP_MULH, 1'b1, 1'b1, SP_DT, SP_DT, M_HALF); n++;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) begin
				p[n] = mk(OP_MAC, k == 0, k == 2, a_op(i, k), mo(M_X + k), M_XM + i); n++;
			end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++) begin
					p[n] = mk(OP_MAC, k == 0, k == 2, a_op(i, k), mo(M_P + 3 * k + j),
						M_AP + 3 * i + j); n++;
				end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++) begin
					p[n] = mk(OP_MAC, k == 0, k == 2, mo(M_AP + 3 * i + k), a_op(j, k),
						M_PM + 3 * i + j); n++;
				end
		for (int k = 0; k < 9; k++) begin
			p[n] = mk(OP_ADD, 1'b0, 1'b1, mo(M_PM + k), SP_Q, M_PM + k); n++;
		end
		// Innovation covariance and its determinant.
		p[n] = mk(OP_ADD, 1'b0, 1'b1, mo(M_PM), SP_RALT, M_S00); n++;
		p[n] = mk(OP_ADD, 1'b0, 1'b1, mo(M_PM + 8), SP_RACC, M_S11); n++;
		p[n] = mk(OP_MAC, 1'b1, 1'b1, mo(M_PM + 2), mo(M_PM + 6), M_T2); n++;
		p[n] = mk(OP_MAC, 1'b1, 1'b1, mo(M_S00), mo(M_S11), M_T1); n++;
		p[n] = mk(OP_SUB, 1'b0, 1'b1, mo(M_T1), mo(M_T2), M_DET); n++;
		bz_pos = n;
		p[n] = mk(OP_BZ, 1'b0, 1'b0, mo(M_DET), SP_ZERO, 0); n++;
		// Update.
		p[n] = mk(OP_NEG, 1'b0, 1'b1, mo(M_PM + 2), SP_ZERO, M_NS01); n++;
		p[n] = mk(OP_NEG, 1'b0, 1'b1, mo(M_PM + 6), SP_ZERO, M_NS10); n++;
		p[n] = mk(OP_DIV, 1'b0, 1'b1, mo(M_S11), mo(M_DET), M_I00); n++;
		p[n] = mk(OP_DIV, 1'b0, 1'b1, mo(M_NS01), mo(M_DET), M_I01); n++;
		p[n] = mk(OP_DIV, 1'b0, 1'b1, mo(M_NS10), mo(M_DET), M_I10); n++;
		p[n] = mk(OP_DIV, 1'b0, 1'b1, mo(M_S00), mo(M_DET), M_I11); n++;
		p[n] = mk(OP_SUB, 1'b0, 1'b1, SP_ALT, mo(M_XM), M_Y0); n++;
		p[n] = mk(OP_SUB, 1'b0, 1'b1, SP_ACC, mo(M_XM + 2), M_Y1); n++;
		for (int i = 0; i < 3; i++) begin
			p[n] = mk(OP_MAC, 1'b1, 1'b0, mo(M_PM + 3 * i), mo(M_I00), 0); n++;
			p[n] = mk(OP_MAC, 1'b0, 1'b1, mo(M_PM + 3 * i + 2), mo(M_I10), M_K + 2 * i); n++;
			p[n] = mk(OP_MAC, 1'b1, 1'b0, mo(M_PM + 3 * i), mo(M_I01), 0); n++;
			p[n] = mk(OP_MAC, 1'b0, 1'b1, mo(M_PM + 3 * i + 2), mo(M_I11),
				M_K + 2 * i + 1); n++;
		end
		for (int i = 0; i < 3; i++) begin
			p[n] = mk(OP_MAC, 1'b1, 1'b0, mo(M_K + 2 * i), mo(M_Y0), 0); n++;
			p[n] = mk(OP_MAC, 1'b0, 1'b1, mo(M_K + 2 * i + 1), mo(M_Y1), M_T1); n++;
			p[n] = mk(OP_ADD, 1'b0, 1'b1, mo(M_XM + i), mo(M_T1), M_X + i); n++;
		end
		for (int i = 0; i < 3; i++) begin
			p[n] = mk(OP_SUB, 1'b0, 1'b1, (i == 0) ? SP_ONE : SP_ZERO, mo(M_K + 2 * i),
				M_IKH + 3 * i); n++;
			p[n] = mk(OP_SUB, 1'b0, 1'b1, (i == 2) ? SP_ONE : SP_ZERO, mo(M_K + 2 * i + 1),
				M_IKH + 3 * i + 2); n++;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++) begin
					p[n] = mk(OP_MAC, k == 0, k == 2, ik_op(i, k), mo(M_PM + 3 * k + j),
						M_P + 3 * i + j); n++;
				end
		jp_pos = n;
		p[n] = mk(OP_JMP, 1'b0, 1'b0, SP_ZERO, SP_ZERO, 0); n++;
		// Singular innovation: keep the prediction.
		p[bz_pos].tgt = 8'(n);
		for (int i = 0; i < 3; i++) begin
			p[n] = mk(OP_ADD, 1'b0, 1'b1, mo(M_XM + i), SP_ZERO, M_X + i); n++;
		end
		for (int k = 0; k < 9; k++) begin
			p[n] = mk(OP_ADD, 1'b0, 1'b1, mo(M_PM + k), SP_ZERO, M_P + k); n++;
		end
		p[jp_pos].tgt = 8'(n);
		for (int i = 0; i < 3; i++) begin
			p[n] = mk(OP_OUT, 1'b0, 1'b0, mo(M_X + i), SP_ZERO, i); n++;
		end
		p[n] = mk(OP_DONE, 1'b0, 1'b0, SP_ZERO, SP_ZERO, 0);
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== design/kaf_mul.sv =====
`default_nettype none

// Saturating fixed-point multiply from four 24x24 partial products.
module kaf_mul #(
	parameter int FRACTION_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [kaf_pkg::DW-1:0]     a,
	input  wire logic signed [kaf_pkg::DW-1:0]     b,
	output logic                                   done,
	output logic signed [kaf_pkg::DW-1:0]          p
);

	localparam int HW = kaf_pkg::DW / 2;
	localparam int PW = 2 * kaf_pkg::DW;
	localparam int RW = PW - FRACTION_BITS;
	localparam logic [PW-1:0] RND = PW'(1) << (FRACTION_BITS - 1);
	localparam logic [RW-1:0] LIM_NEG = RW'(1) << (kaf_pkg::DW - 1);
	localparam logic [RW-1:0] LIM_POS = LIM_NEG - RW'(1);

	logic              busy_q;
	logic [2:0]        cnt_q;
	logic [kaf_pkg::DW-1:0] xm_q, ym_q;
	logic              neg_q;
	logic [PW-1:0]     acc_q;
	logic [RW-1:0]     r_q;
	logic [HW-1:0]     xh, yh;
	logic [2*HW-1:0]   pp;
	logic [PW-1:0]     pp_sh;

	always_comb begin
		xh = cnt_q[0] ? xm_q[2*HW-1:HW] : xm_q[HW-1:0];
		yh = cnt_q[1] ? ym_q[2*HW-1:HW] : ym_q[HW-1:0];
		pp = xh * yh;
		unique case ({cnt_q[1], cnt_q[0]})
			2'b00:         pp_sh = PW'(pp);
			2'b01, 2'b10:  pp_sh = PW'(pp) << HW;
			default:       pp_sh = PW'(pp) << (2 * HW);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd5) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xm_q  <= kaf_pkg::mag(a);
			ym_q  <= kaf_pkg::mag(b);
			neg_q <= a[kaf_pkg::DW-1] ^ b[kaf_pkg::DW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (!cnt_q[2]) acc_q <= acc_q + pp_sh;
			if (cnt_q == 3'd4) r_q <= RW'((acc_q + RND) >> FRACTION_BITS);
		end
	end

	assign done = busy_q && (cnt_q == 3'd5);

	always_comb begin
		if (neg_q) p = (r_q > LIM_NEG) ? kaf_pkg::VMIN : -$signed(r_q[kaf_pkg::DW-1:0]);
		else p = (r_q > LIM_POS) ? kaf_pkg::VMAX : $signed(r_q[kaf_pkg::DW-1:0]);
	end

endmodule

`default_nettype wire

// ===== design/kaf_div.sv =====
`default_nettype none

// Saturating fixed-point divide n * 2^F / d, restoring radix 2, one quotient bit a cycle.
module kaf_div #(
	parameter int FRACTION_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [kaf_pkg::DW-1:0]     n,
	input  wire logic signed [kaf_pkg::DW-1:0]     d,
	output logic                                   done,
	output logic signed [kaf_pkg::DW-1:0]          q
);

	localparam int DW = kaf_pkg::DW;
	localparam int NW = DW + FRACTION_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam logic [NW:0] LIM_NEG = (NW+1)'(1) << (DW - 1);
	localparam logic [NW:0] LIM_POS = LIM_NEG - (NW+1)'(1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q, ud_q;
	logic          neg_q, zd_q, nz_q, nneg_q;
	logic [DW:0]   remx;
	logic          ge;
	logic [NW:0]   qr;

	always_comb begin
		remx = {rem_q, num_q[NW-1]};
		ge   = remx >= {1'b0, ud_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
			else busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {kaf_pkg::mag(n), {FRACTION_BITS{1'b0}}};
			ud_q   <= kaf_pkg::mag(d);
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= n[DW-1] ^ d[DW-1];
			zd_q   <= (d == '0);
			nz_q   <= (n != '0);
			nneg_q <= n[DW-1];
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? DW'(remx - {1'b0, ud_q}) : remx[DW-1:0];
			num_q <= num_q << 1;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = busy_q && (cnt_q == '0);

	always_comb begin
		qr = {1'b0, quo_q} + (NW+1)'({rem_q, 1'b0} >= {1'b0, ud_q});
		if (zd_q) q = nz_q ? (nneg_q ? kaf_pkg::VMIN : kaf_pkg::VMAX) : '0;
		else if (neg_q) q = (qr > LIM_NEG) ? kaf_pkg::VMIN : -$signed(qr[DW-1:0]);
		else q = (qr > LIM_POS) ? kaf_pkg::VMAX : $signed(qr[DW-1:0]);
	end

endmodule

`default_nettype wire

// ===== design/kalman_altitude_filter.sv =====
// Constant-acceleration Kalman filter for altitude, three states, signed Q16.32.
// Input channel s_*: one transfer carries an altitude and an acceleration sample.
// Output channel m_*: one transfer per sample with the filtered altitude,
// velocity and acceleration, each saturated to 48 bits.
// Configuration channel cfg_*: register index and data; always ready. Writes are
// meant for an idle block. Writing the initial altitude restarts the filter.
// A sample is processed by a microcoded sequencer around one scratch memory that
// holds the state, the covariance and all intermediate matrices. Each step reads
// its operands, runs one shared 24x24 multiplier or a radix-2 divider, and writes
// back. A full update takes 111 multiplies, four divides and 25 add steps; a
// singular innovation skips the update. One sample is in flight at a time, so a
// new sample can be taken in the cycle after the previous result has been loaded
// into the output register.
// The result sits in an output register, so a stalled receiver does not keep the
// block from taking and computing the next sample; only the hand-off of the next
// result waits for the register to be free.
// After reset the configuration holds its defaults, the state is the initial
// altitude with zero velocity and acceleration, and the covariance is identity.
`default_nettype none

module kalman_altitude_filter #(
	parameter int FRACTION_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [47:0] altitude_meas, [95:48] accel_meas
	input  wire logic [95:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [47:0] est_altitude, [95:48] est_velocity, [143:96] est_accel
	output logic [143:0]      m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [47:0]  cfg_data
);

	localparam int DW = kaf_pkg::DW;
	localparam logic [32:0] TS_RST = 33'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);
	localparam logic [32:0] PN_RST = 33'(((64'd1 << FRACTION_BITS) + 64'd5000) / 64'd10000);
	localparam logic [32:0] RA_RST = 33'(((64'd1 << FRACTION_BITS) + 64'd2) / 64'd4);
	localparam logic [32:0] RC_RST = 33'(((64'd3 << FRACTION_BITS) + 64'd2) / 64'd4);
	localparam logic [DW-1:0] IA_RST = DW'(64'd1500 << FRACTION_BITS);
	localparam logic [DW-1:0] ONE = DW'(64'd1 << FRACTION_BITS);
	localparam kaf_pkg::prog_t PROG = kaf_pkg::build_prog();

	kaf_pkg::state_t state_q, state_d;
	kaf_pkg::instr_t ins;

	logic [32:0]   ts_q, pn_q, ran_q, rac_q;
	logic [DW-1:0] ia_q;
	logic [7:0]    pc_q;
	logic [kaf_pkg::NSTATE-1:0] vld_q;
	logic [DW-1:0] alt_in_q, acc_in_q;
	logic [DW-1:0] rda_q, rdb_q;
	logic signed [DW-1:0] mac_q, res_q;
	logic signed [DW-1:0] est_q [3];
	logic [143:0]  m_tdata_q;
	logic          m_tvalid_q;
	logic [DW-1:0] mem [kaf_pkg::MEM_DEPTH];

	logic signed [DW-1:0] opa, opb, prod, quo, mac_n;
	logic mul_start, mul_done, div_start, div_done, out_load;

	// Operand fetch: a special value, or a memory word with reset values for
	// state entries not yet written since the last restart.
	function automatic logic [DW-1:0] opnd(input logic [6:0] code, input logic [DW-1:0] rd,
			input logic [kaf_pkg::NSTATE-1:0] vld, input logic [DW-1:0] ia,
			input logic [32:0] ts, input logic [32:0] pn, input logic [32:0] ran,
			input logic [32:0] rac, input logic [DW-1:0] alt, input logic [DW-1:0] acc);
		logic [5:0] idx;
		idx = code[5:0];
		if (code[6]) begin
			unique case (code)
				kaf_pkg::SP_ONE:  return ONE;
				kaf_pkg::SP_DT:   return DW'(ts);
				kaf_pkg::SP_Q:    return DW'(pn);
				kaf_pkg::SP_RALT: return DW'(ran);
				kaf_pkg::SP_RACC: return DW'(rac);
				kaf_pkg::SP_ALT:  return alt;
				kaf_pkg::SP_ACC:  return acc;
				default:          return '0;
			endcase
		end
		if (idx < 6'(kaf_pkg::NSTATE) && !vld[idx[3:0]]) begin
			if (idx == 6'(kaf_pkg::M_X)) return ia;
			if (idx == 6'(kaf_pkg::M_P) || idx == 6'(kaf_pkg::M_P + 4) ||
					idx == 6'(kaf_pkg::M_P + 8)) return ONE;
			return '0;
		end
		return rd;
	endfunction

	assign ins = PROG[pc_q];
	assign opa = opnd(ins.a, rda_q, vld_q, ia_q, ts_q, pn_q, ran_q, rac_q, alt_in_q, acc_in_q);
	assign opb = opnd(ins.b, rdb_q, vld_q, ia_q, ts_q, pn_q, ran_q, rac_q, alt_in_q, acc_in_q);
	assign mac_n = kaf_pkg::sadd(ins.clr ? '0 : mac_q, prod);

	kaf_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
		.clk, .arst_n, .start(mul_start), .a(opa), .b(opb), .done(mul_done), .p(prod)
	);

	kaf_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk, .arst_n, .start(div_start), .n(opa), .d(opb), .done(div_done), .q(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= kaf_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			kaf_pkg::ST_IDLE:  if (s_tvalid) state_d = kaf_pkg::ST_FETCH;
			kaf_pkg::ST_FETCH: state_d = kaf_pkg::ST_EXEC;
			kaf_pkg::ST_EXEC: begin
				unique case (ins.op)
					kaf_pkg::OP_MAC, kaf_pkg::OP_MULH: begin
						mul_start = 1'b1;
						state_d   = kaf_pkg::ST_MUL;
					end
					kaf_pkg::OP_DIV: begin
						div_start = 1'b1;
						state_d   = kaf_pkg::ST_DIV;
					end
					kaf_pkg::OP_ADD, kaf_pkg::OP_SUB, kaf_pkg::OP_NEG: state_d = kaf_pkg::ST_WB;
					kaf_pkg::OP_DONE: state_d = kaf_pkg::ST_DONE;
					default: state_d = kaf_pkg::ST_FETCH;
				endcase
			end
			kaf_pkg::ST_MUL: begin
				if (mul_done)
					state_d = (ins.op == kaf_pkg::OP_MULH || ins.wr) ? kaf_pkg::ST_WB
						: kaf_pkg::ST_FETCH;
			end
			kaf_pkg::ST_DIV: if (div_done) state_d = kaf_pkg::ST_WB;
			kaf_pkg::ST_WB:  state_d = kaf_pkg::ST_FETCH;
			kaf_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = kaf_pkg::ST_IDLE;
				end
			end
			default: state_d = kaf_pkg::ST_IDLE;
		endcase
	end

	// Control state: configuration, program counter, valid bits, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q       <= TS_RST;
			pn_q       <= PN_RST;
			ran_q      <= RA_RST;
			rac_q      <= RC_RST;
			ia_q       <= IA_RST;
			pc_q       <= '0;
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					kaf_pkg::REG_TIME_STEP:     ts_q  <= cfg_data[32:0];
					kaf_pkg::REG_PROCESS_NOISE: pn_q  <= cfg_data[32:0];
					kaf_pkg::REG_ALT_NOISE:     ran_q <= cfg_data[32:0];
					kaf_pkg::REG_ACCEL_NOISE:   rac_q <= cfg_data[32:0];
					kaf_pkg::REG_INIT_ALT: begin
						ia_q  <= cfg_data;
						vld_q <= '0;
					end
					default: ;
				endcase
			end
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				kaf_pkg::ST_IDLE: pc_q <= '0;
				kaf_pkg::ST_EXEC: begin
					if (ins.op == kaf_pkg::OP_BZ)
						pc_q <= (opa == '0) ? ins.tgt : pc_q + 8'd1;
					else if (ins.op == kaf_pkg::OP_JMP) pc_q <= ins.tgt;
					else if (ins.op == kaf_pkg::OP_OUT) pc_q <= pc_q + 8'd1;
				end
				kaf_pkg::ST_MUL:
					if (mul_done && ins.op == kaf_pkg::OP_MAC && !ins.wr) pc_q <= pc_q + 8'd1;
				kaf_pkg::ST_WB: begin
					pc_q <= pc_q + 8'd1;
					if (ins.dst < 6'(kaf_pkg::NSTATE)) vld_q[ins.dst[3:0]] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Scratch memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (state_q == kaf_pkg::ST_WB) mem[ins.dst] <= res_q;
		rda_q <= mem[ins.a[5:0]];
		rdb_q <= mem[ins.b[5:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == kaf_pkg::ST_IDLE && s_tvalid) begin
			alt_in_q <= s_tdata[47:0];
			acc_in_q <= s_tdata[95:48];
		end
		if (state_q == kaf_pkg::ST_EXEC) begin
			unique case (ins.op)
				kaf_pkg::OP_ADD: res_q <= kaf_pkg::sadd(opa, opb);
				kaf_pkg::OP_SUB: res_q <= kaf_pkg::ssub(opa, opb);
				kaf_pkg::OP_NEG: res_q <= kaf_pkg::sneg(opa);
				kaf_pkg::OP_OUT: est_q[ins.dst[1:0]] <= opa;
				default: ;
			endcase
		end
		if (state_q == kaf_pkg::ST_MUL && mul_done) begin
			if (ins.op == kaf_pkg::OP_MULH) res_q <= prod >>> 1;
			else begin
				mac_q <= mac_n;
				res_q <= mac_n;
			end
		end
		if (state_q == kaf_pkg::ST_DIV && div_done) res_q <= quo;
		if (out_load) m_tdata_q <= {est_q[2], est_q[1], est_q[0]};
	end

	assign s_tready  = (state_q == kaf_pkg::ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== design/kaf_chk.sv =====
`default_nettype none

module kaf_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [143:0] m_tdata
);

	// A result waiting on the receiver holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One sample at a time: after a transfer in, the input side closes.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// A new result appears only at the end of a computation.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without computation");

	// No result can follow an input transfer in the very next cycle.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

endmodule

bind kalman_altitude_filter kaf_chk u_kaf_chk (.*);

`default_nettype wire

// ===== tb/kalman_altitude_filter_tb.sv =====
`default_nettype none

// Testbench for the three-state altitude Kalman filter.
// A behavioral predictor written here in 48-bit saturating fixed point tracks
// the filter state and covariance, and every output transfer is compared with
// the oldest queued estimate. A short directed table comes first, then
// random samples in three phases with different idling on both channels.
module kalman_altitude_filter_tb;

	localparam int FB = 32;
	localparam longint FX_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint FX_MIN = -FX_MAX - 1;
	localparam longint ONE = 64'sd1 << FB;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SQUEEZE_CYCLES = 5000;
	localparam int DRAIN_CYCLES = 2000;
	localparam int RANDOM_PER_PHASE = 380;

	typedef longint mat_t [9];

	typedef struct {
		logic signed [47:0] alt;
		logic signed [47:0] vel;
		logic signed [47:0] acc;
	} triple_t;

	// One row of the directed table: either a register write or a sample,
	// the latter optionally with a hand-derived estimate.
	typedef struct {
		bit                 is_write;
		logic [2:0]         index;
		logic [47:0]        value;
		logic signed [47:0] alt;
		logic signed [47:0] acc;
		bit                 known;
		triple_t            want;
	} dir_row_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	// [47:0] altitude_meas, [95:48] accel_meas
	logic [95:0]   s_tdata;
	logic          m_tvalid;
	logic          m_tready;
	// [47:0] est_altitude, [95:48] est_velocity, [143:96] est_accel
	logic [143:0]  m_tdata;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [2:0]    cfg_index;
	logic [47:0]   cfg_data;

	kalman_altitude_filter uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor copy of the configuration and of the filter state.
	logic [32:0]        pr_dt, pr_q, pr_ralt, pr_racc;
	logic signed [47:0] pr_init;
	logic signed [47:0] pr_x [3];
	logic signed [47:0] pr_p [9];

	triple_t  estimate_q [$];
	dir_row_t dir_rows [$];
	int       fail_count;
	int       snd_pct;
	int       rcv_pct;
	bit       squeeze_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Saturating fixed-point arithmetic of the filter.
	// ---------------------------------------------------------------------
	function automatic longint clamp48(input longint v);
		if (v > FX_MAX) return FX_MAX;
		if (v < FX_MIN) return FX_MIN;
		return v;
	endfunction

	function automatic longint fx_add(input longint a, input longint b);
		return clamp48(a + b);
	endfunction

	function automatic longint fx_sub(input longint a, input longint b);
		return clamp48(a - b);
	endfunction

	// Applies the sign to a rounded magnitude and saturates it.
	function automatic longint fx_finish(input bit neg, input logic [127:0] m);
		if (neg) begin
			if (m > 128'h8000_0000_0000) return FX_MIN;
			return -longint'(m[63:0]);
		end
		if (m > 128'h7FFF_FFFF_FFFF) return FX_MAX;
		return longint'(m[63:0]);
	endfunction

	// Product rounded to nearest, ties away from zero (rounding on magnitudes).
	function automatic longint fx_mul(input longint a, input longint b);
		logic [63:0]  ma, mb;
		logic [127:0] p;
		ma = (a < 0) ? 64'(-a) : 64'(a);
		mb = (b < 0) ? 64'(-b) : 64'(b);
		p = 128'(ma) * 128'(mb);
		p = (p + (128'd1 << (FB - 1))) >> FB;
		return fx_finish((a < 0) != (b < 0), p);
	endfunction

	function automatic longint fx_div(input longint n, input longint d);
		logic [63:0]  un, ud;
		logic [127:0] num, q, r;
		if (d == 0) return (n > 0) ? FX_MAX : ((n < 0) ? FX_MIN : 64'sd0);
		un = (n < 0) ? 64'(-n) : 64'(n);
		ud = (d < 0) ? 64'(-d) : 64'(d);
		num = 128'(un) << FB;
		q = num / 128'(ud);
		r = num - q * 128'(ud);
		if ((r << 1) >= 128'(ud)) q = q + 1;
		return fx_finish((n < 0) != (d < 0), q);
	endfunction

	// 3x3 product, each dot product summed left to right with saturation.
	function automatic mat_t mat_mul(input mat_t a, input mat_t b);
		mat_t   c;
		longint s;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				s = 0;
				for (int k = 0; k < 3; k++) s = fx_add(s, fx_mul(a[3 * i + k], b[3 * k + j]));
				c[3 * i + j] = s;
			end
		return c;
	endfunction

	// Writing the initial altitude puts the filter back to its starting point.
	task automatic restart_filter();
		pr_x[0] = pr_init;
		pr_x[1] = '0;
		pr_x[2] = '0;
		for (int k = 0; k < 9; k++) pr_p[k] = (k % 4 == 0) ? 48'(ONE) : '0;
	endtask

	task automatic apply_register(input logic [2:0] index, input logic [47:0] value);
		case (index)
			kaf_pkg::REG_TIME_STEP: begin
				pr_dt = value[32:0];
			end
			kaf_pkg::REG_PROCESS_NOISE: begin
				pr_q = value[32:0];
			end
			kaf_pkg::REG_ALT_NOISE: begin
				pr_ralt = value[32:0];
			end
			kaf_pkg::REG_ACCEL_NOISE: begin
				pr_racc = value[32:0];
			end
			kaf_pkg::REG_INIT_ALT: begin
				pr_init = value;
				restart_filter();
			end
			default: begin
			end
		endcase
	endtask

	// One predict and update step; returns the new state triple.
	task automatic filter_step(input longint z_alt, input longint z_acc, output triple_t est);
		longint dt, half, s00, s01, s10, s11, det;
		longint i00, i01, i10, i11, y0, y1, s;
		longint xm [3];
		longint g0 [3];
		longint g1 [3];
		mat_t   a, at, pc, pm, ikh, pn;
		dt = longint'(pr_dt);
		half = fx_mul(dt, dt) >>> 1;
		a = '{ONE, dt, half, 0, ONE, dt, 0, 0, ONE};
		at = '{ONE, 0, 0, dt, ONE, 0, half, dt, ONE};
		for (int k = 0; k < 9; k++) pc[k] = longint'(pr_p[k]);
		for (int i = 0; i < 3; i++) begin
			s = 0;
			for (int k = 0; k < 3; k++) s = fx_add(s, fx_mul(a[3 * i + k], longint'(pr_x[k])));
			xm[i] = s;
		end
		pm = mat_mul(mat_mul(a, pc), at);
		for (int k = 0; k < 9; k++) pm[k] = fx_add(pm[k], longint'(pr_q));
		s00 = fx_add(pm[0], longint'(pr_ralt));
		s01 = pm[2];
		s10 = pm[6];
		s11 = fx_add(pm[8], longint'(pr_racc));
		det = fx_sub(fx_mul(s00, s11), fx_mul(s01, s10));
		if (det == 0) begin
			// Singular innovation: the prediction stands.
			for (int i = 0; i < 3; i++) pr_x[i] = 48'(xm[i]);
			for (int k = 0; k < 9; k++) pr_p[k] = 48'(pm[k]);
		end else begin
			i00 = fx_div(s11, det);
			i01 = fx_div(clamp48(-s01), det);
			i10 = fx_div(clamp48(-s10), det);
			i11 = fx_div(s00, det);
			y0 = fx_sub(z_alt, xm[0]);
			y1 = fx_sub(z_acc, xm[2]);
			for (int i = 0; i < 3; i++) begin
				g0[i] = fx_add(fx_mul(pm[3 * i], i00), fx_mul(pm[3 * i + 2], i10));
				g1[i] = fx_add(fx_mul(pm[3 * i], i01), fx_mul(pm[3 * i + 2], i11));
				pr_x[i] = 48'(fx_add(xm[i], fx_add(fx_mul(g0[i], y0), fx_mul(g1[i], y1))));
				ikh[3 * i] = fx_sub((i == 0) ? ONE : 0, g0[i]);
				ikh[3 * i + 1] = (i == 1) ? ONE : 0;
				ikh[3 * i + 2] = fx_sub((i == 2) ? ONE : 0, g1[i]);
			end
			pn = mat_mul(ikh, pm);
			for (int k = 0; k < 9; k++) pr_p[k] = 48'(pn[k]);
		end
		est.alt = pr_x[0];
		est.vel = pr_x[1];
		est.acc = pr_x[2];
	endtask

	// ---------------------------------------------------------------------
	// Drivers. Every task is entered and left at a falling edge.
	// ---------------------------------------------------------------------
	task automatic write_register(input logic [2:0] index, input logic [47:0] value);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		apply_register(index, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Offers one sample; the expectation is worked out once the transfer happens.
	// A typed-in estimate, when given, replaces the predicted one in the queue.
	task automatic send_sample(input logic signed [47:0] alt, input logic signed [47:0] acc,
			input bit known, input triple_t want);
		triple_t est;
		while ($urandom_range(99, 0) < snd_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {acc, alt};
		do @(posedge clk); while (!s_tready);
		filter_step(longint'(alt), longint'(acc), est);
		estimate_q.push_back(known ? want : est);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (estimate_q.size() != 0) @(negedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off when asked for so that the
	// output register stays full and the block has to stop taking samples.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				m_tready = 1'b0;
				repeat (SQUEEZE_CYCLES) @(negedge clk);
			end
			m_tready = ($urandom_range(99, 0) >= rcv_pct);
		end
	end

	// Scoreboard on the output channel.
	always @(posedge clk) begin
		triple_t exp_t;
		triple_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.alt = m_tdata[47:0];
			got.vel = m_tdata[95:48];
			got.acc = m_tdata[143:96];
			if (estimate_q.size() == 0) begin
				$error("output transfer with no estimate pending: %h", m_tdata);
				fail_count++;
			end else begin
				exp_t = estimate_q.pop_front();
				if (got.alt !== exp_t.alt) begin
					$error("est_altitude expected %0d got %0d", exp_t.alt, got.alt);
					fail_count++;
				end
				if (got.vel !== exp_t.vel) begin
					$error("est_velocity expected %0d got %0d", exp_t.vel, got.vel);
					fail_count++;
				end
				if (got.acc !== exp_t.acc) begin
					$error("est_accel expected %0d got %0d", exp_t.acc, got.acc);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer on any channel ends the run.
	always @(posedge clk) begin
		int quiet;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus.
	// ---------------------------------------------------------------------
	function automatic dir_row_t row_write(input logic [2:0] index, input logic [47:0] value);
		dir_row_t r;
		r = '{default: '0};
		r.is_write = 1'b1;
		r.index = index;
		r.value = value;
		return r;
	endfunction

	function automatic dir_row_t row_sample(input logic signed [47:0] alt,
			input logic signed [47:0] acc);
		dir_row_t r;
		r = '{default: '0};
		r.alt = alt;
		r.acc = acc;
		return r;
	endfunction

	function automatic dir_row_t row_known(input logic signed [47:0] alt,
			input logic signed [47:0] acc, input triple_t want);
		dir_row_t r;
		r = row_sample(alt, acc);
		r.known = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic longint signed_range(input int bits);
		return longint'({$urandom, $urandom} & ((64'd1 << bits) - 1)) - (64'sd1 << (bits - 1));
	endfunction

	// Picks a configuration for one random phase; the four 33-bit registers get
	// junk above the register width in the data word.
	task automatic random_config(input bit harsh);
		logic [32:0] v;
		for (int r = 0; r < 4; r++) begin
			case ($urandom_range(harsh ? 3 : 5, 0))
				0: v = 33'd0;
				1: v = 33'h1_0000_0000;
				2: v = {1'b0, $urandom};
				default: v = (r == 0) ? 33'($urandom_range(32'h2000_0000, 0))
					: 33'($urandom_range(32'h4000_0000, 0));
			endcase
			write_register(3'(r), {15'($urandom), v});
		end
		write_register(REG_UNUSED, 48'({$urandom, $urandom}));
		write_register(kaf_pkg::REG_INIT_ALT, 48'(signed_range(44)));
	endtask

	initial begin
		triple_t        none;
		triple_t        hold;
		dir_row_t       row;
		longint         tr_alt, tr_vel, tr_acc;
		logic signed [47:0] z_alt, z_acc;

		none = '{default: '0};
		fail_count = 0;
		snd_pct = 35;
		rcv_pct = 48;
		squeeze_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// Reset defaults of the predictor: dt 0.1, q 0.0001, R 0.25 and 0.75,
		// starting altitude 1500.
		pr_dt = 33'd429496730;
		pr_q = 33'd429497;
		pr_ralt = 33'd1073741824;
		pr_racc = 33'd3221225472;
		pr_init = 48'sd6442450944000;
		restart_filter();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table. With dt, q and both noises at zero, the first sample
		// after a restart copies the measured altitude and acceleration into the
		// state and leaves a covariance that makes the next innovation singular,
		// so the following samples are ignored and the state holds.
		hold = '{48'sd7 <<< 32, 48'sd0, -(48'sd3 <<< 32)};
		dir_rows.push_back(row_sample(48'sd6442450944000, 48'sd0));
		dir_rows.push_back(row_sample(48'sd0, 48'sd0));
		dir_rows.push_back(row_sample(kaf_pkg::VMAX, kaf_pkg::VMAX));
		dir_rows.push_back(row_sample(kaf_pkg::VMIN, kaf_pkg::VMIN));
		dir_rows.push_back(row_sample(kaf_pkg::VMAX, kaf_pkg::VMIN));
		dir_rows.push_back(row_sample(kaf_pkg::VMIN, kaf_pkg::VMAX));
		dir_rows.push_back(row_write(kaf_pkg::REG_TIME_STEP, 48'd0));
		dir_rows.push_back(row_write(kaf_pkg::REG_PROCESS_NOISE, 48'd0));
		dir_rows.push_back(row_write(kaf_pkg::REG_ALT_NOISE, 48'd0));
		dir_rows.push_back(row_write(kaf_pkg::REG_ACCEL_NOISE, 48'd0));
		dir_rows.push_back(row_write(REG_UNUSED, 48'hFFFF_FFFF_FFFF));
		dir_rows.push_back(row_write(kaf_pkg::REG_INIT_ALT, 48'(64'sd5 <<< 32)));
		dir_rows.push_back(row_known(hold.alt, hold.acc, hold));
		dir_rows.push_back(row_known(kaf_pkg::VMAX, kaf_pkg::VMIN, hold));
		dir_rows.push_back(row_known(48'sd0, kaf_pkg::VMAX, hold));
		dir_rows.push_back(row_write(kaf_pkg::REG_INIT_ALT, kaf_pkg::VMAX));
		dir_rows.push_back(row_sample(kaf_pkg::VMIN, kaf_pkg::VMAX));
		dir_rows.push_back(row_write(kaf_pkg::REG_INIT_ALT, kaf_pkg::VMIN));
		dir_rows.push_back(row_sample(kaf_pkg::VMAX, kaf_pkg::VMIN));
		dir_rows.push_back(row_write(kaf_pkg::REG_TIME_STEP, 48'h1_0000_0000));
		dir_rows.push_back(row_write(kaf_pkg::REG_PROCESS_NOISE, 48'h1_0000_0000));
		dir_rows.push_back(row_write(kaf_pkg::REG_ALT_NOISE, 48'h1_0000_0000));
		dir_rows.push_back(row_write(kaf_pkg::REG_ACCEL_NOISE, 48'h1_0000_0000));
		dir_rows.push_back(row_sample(kaf_pkg::VMAX, kaf_pkg::VMAX));
		dir_rows.push_back(row_sample(48'sd0, 48'sd0));
		dir_rows.push_back(row_sample(kaf_pkg::VMIN, kaf_pkg::VMIN));

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_write) begin
				// Registers change only with nothing in flight.
				wait_idle();
				write_register(row.index, row.value);
			end else begin
				send_sample(row.alt, row.acc, row.known, row.known ? row.want : none);
			end
		end

		// Random phases: the receiver idles more in the first, the sender in the
		// second, and nobody in the third, which starts with a long hold-off.
		for (int ph = 0; ph < 3; ph++) begin
			wait_idle();
			snd_pct = (ph == 0) ? 35 : ((ph == 1) ? 48 : 0);
			rcv_pct = (ph == 0) ? 48 : ((ph == 1) ? 35 : 0);
			random_config(ph == 1);
			if (ph == 2) squeeze_req = 1'b1;
			tr_alt = longint'(pr_init);
			tr_vel = 0;
			tr_acc = 0;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if ($urandom_range(99, 0) < 80) begin
					// A smooth flight path with sensor noise on top.
					tr_acc = tr_acc + signed_range(30);
					if (tr_acc > (64'sd1 <<< 38) || tr_acc < -(64'sd1 <<< 38)) tr_acc = 0;
					tr_vel = tr_vel + (tr_acc >>> 4);
					if (tr_vel > (64'sd1 <<< 40) || tr_vel < -(64'sd1 <<< 40)) tr_vel = 0;
					tr_alt = tr_alt + (tr_vel >>> 4);
					if (tr_alt > (64'sd1 <<< 45) || tr_alt < -(64'sd1 <<< 45)) tr_alt = 0;
					z_alt = 48'(tr_alt + signed_range(33));
					z_acc = 48'(tr_acc + signed_range(33));
				end else begin
					z_alt = 48'({$urandom, $urandom});
					z_acc = 48'({$urandom, $urandom});
				end
				send_sample(z_alt, z_acc, 1'b0, none);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
